// ===== sv/smmt_pkg.sv =====
// Package for the sensor median, minimum and maximum tracker.
// Holds the shared constants, codes, state and result kinds, and controller links.
// No dependencies.
package smmt_pkg;

    localparam int WINDOW_SIZE_DEF = 7;
    localparam int SAMPLE_BITS_DEF = 12;

    localparam int VALUE_W    = 16;
    localparam int CHAR_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int MAX_RESET  = 174;
    localparam int MIN_RESET  = 1205;
    localparam int MM_MIN_W   = 11;

    localparam logic [VALUE_W-1:0] REF_RESET = 16'h3000;

    localparam logic [CHAR_W-1:0] CMD_MINMAX = 8'h40;
    localparam logic [CHAR_W-1:0] CMD_MEDIAN = 8'h4B;
    localparam logic [CHAR_W-1:0] CMD_REF    = 8'h23;

    localparam logic OP_SAMPLE  = 1'b0;
    localparam logic OP_COMMAND = 1'b1;

    localparam logic REG_REF_CODE = 1'b0;

    typedef enum logic [1:0] {
        KIND_MIN = 2'd0,
        KIND_MAX = 2'd1,
        KIND_MED = 2'd2,
        KIND_REF = 2'd3
    } t_smmt_kind;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_MAX  = 2'd1,
        S_SORT = 2'd2,
        S_MED  = 2'd3
    } t_smmt_state;

    typedef struct packed {
        logic       upd_sample;
        logic       load_sort;
        logic       sort_step;
        logic       out_load;
        t_smmt_kind out_sel;
    } t_smmt_cmd;

    typedef struct packed {
        logic is_sample;
        logic is_minmax;
        logic is_median;
        logic is_ref;
        logic out_free;
        logic sort_done;
    } t_smmt_sts;

endpackage

// ===== sv/smmt_if.sv =====
// Handshake channel interfaces for the tracker: input items and result beats.
// Depends on smmt_pkg.
interface smmt_in_if
    import smmt_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [CHAR_W-1:0]      command_char;

    modport source (output valid, output opcode, output sample, output command_char,
                    input ready);
    modport sink   (input valid, input opcode, input sample, input command_char,
                    output ready);
endinterface

interface smmt_out_if
    import smmt_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic [1:0]         kind;
    logic               last;

    modport source (output valid, output value, output kind, output last, input ready);
    modport sink   (input valid, input value, input kind, input last, output ready);
endinterface

// ===== sv/smmt_ctrl.sv =====
// Controller state machine of the tracker: sequences accepts, sorting and result loads.
// Depends on smmt_pkg.
module smmt_ctrl
    import smmt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_smmt_sts i_sts,
    output logic      o_in_ready,
    output t_smmt_cmd o_cmd
);

    t_smmt_state r_state;
    t_smmt_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_cmd.upd_sample  = 1'b0;
        o_cmd.load_sort   = 1'b0;
        o_cmd.sort_step   = 1'b0;
        o_cmd.out_load    = 1'b0;
        o_cmd.out_sel     = KIND_MIN;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_sts.out_free;
                if (i_in_valid && i_sts.out_free) begin
                    if (i_sts.is_sample) begin
                        o_cmd.upd_sample = 1'b1;
                    end else if (i_sts.is_minmax) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = KIND_MIN;
                        n_state        = S_MAX;
                    end else if (i_sts.is_median) begin
                        o_cmd.load_sort = 1'b1;
                        n_state         = S_SORT;
                    end else if (i_sts.is_ref) begin
                        o_cmd.out_load = 1'b1;
                        o_cmd.out_sel  = KIND_REF;
                    end
                end
            end
            S_MAX: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = KIND_MAX;
                    n_state        = S_IDLE;
                end
            end
            S_SORT: begin
                o_cmd.sort_step = 1'b1;
                if (i_sts.sort_done) begin
                    n_state = S_MED;
                end
            end
            S_MED: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = KIND_MED;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/smmt_dp.sv =====
// Datapath of the tracker: running min and max, sample window, sort lanes, result register.
// Depends on smmt_pkg.
module smmt_dp
    import smmt_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_smmt_cmd              i_cmd,
    output t_smmt_sts              o_sts,
    input  logic                   i_opcode,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic [CHAR_W-1:0]      i_command_char,
    input  logic [VALUE_W-1:0]     i_ref_code,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [VALUE_W-1:0]     o_value,
    output logic [1:0]             o_kind,
    output logic                   o_last
);

    localparam int IDX_W   = $clog2(WINDOW_SIZE);
    localparam int MM_BITS = (SAMPLE_BITS > MM_MIN_W) ? SAMPLE_BITS : MM_MIN_W;
    localparam int MID     = WINDOW_SIZE / 2;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_SIZE - 1);

    logic [SAMPLE_BITS-1:0] r_window [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] r_sort   [WINDOW_SIZE];
    logic [SAMPLE_BITS-1:0] n_sort   [WINDOW_SIZE];
    logic [IDX_W-1:0]       r_wpos;
    logic [IDX_W-1:0]       r_cnt;
    logic [MM_BITS-1:0]     r_max;
    logic [MM_BITS-1:0]     r_min;
    logic [MM_BITS-1:0]     s_ext;
    logic                   r_out_valid;
    logic [VALUE_W-1:0]     r_value;
    logic [1:0]             r_kind;
    logic                   r_last;
    logic [VALUE_W-1:0]     n_value;

    assign s_ext = MM_BITS'(i_sample);

    assign o_sts.is_sample = (i_opcode == OP_SAMPLE);
    assign o_sts.is_minmax = (i_opcode == OP_COMMAND) && (i_command_char == CMD_MINMAX);
    assign o_sts.is_median = (i_opcode == OP_COMMAND) && (i_command_char == CMD_MEDIAN);
    assign o_sts.is_ref    = (i_opcode == OP_COMMAND) && (i_command_char == CMD_REF);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.sort_done = (r_cnt == IDX_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_max  <= MM_BITS'(MAX_RESET);
            r_min  <= MM_BITS'(MIN_RESET);
            for (int i = 0; i < WINDOW_SIZE; i++) begin
                r_window[i] <= '0;
            end
        end else if (i_cmd.upd_sample) begin
            if (s_ext > r_max) begin
                r_max <= s_ext;
            end
            if (s_ext < r_min) begin
                r_min <= s_ext;
            end
            r_window[r_wpos] <= i_sample;
            r_wpos <= (r_wpos == IDX_LAST) ? '0 : r_wpos + 1'b1;
        end
    end

    // Odd-even transposition: one phase of disjoint compare-exchanges per cycle.
    always_comb begin
        n_sort = r_sort;
        for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
            if ((1'(i) == r_cnt[0]) && (r_sort[i] > r_sort[i+1])) begin
                n_sort[i]   = r_sort[i+1];
                n_sort[i+1] = r_sort[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.load_sort) begin
            r_cnt <= '0;
        end else if (i_cmd.sort_step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sort) begin
            r_sort <= r_window;
        end else if (i_cmd.sort_step) begin
            r_sort <= n_sort;
        end
    end

    always_comb begin
        case (i_cmd.out_sel)
            KIND_MIN: n_value = VALUE_W'(r_min);
            KIND_MAX: n_value = VALUE_W'(r_max);
            KIND_MED: n_value = VALUE_W'(r_sort[MID]);
            KIND_REF: n_value = i_ref_code;
            default:  n_value = i_ref_code;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_value <= n_value;
            r_kind  <= i_cmd.out_sel;
            r_last  <= (i_cmd.out_sel != KIND_MIN);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_kind      = r_kind;
    assign o_last      = r_last;

endmodule

// ===== sv/sensor_median_min_max_tracker.sv =====
// Channel     Dir  Fields                               Handshake
// i_in        in   opcode, sample, command_char         valid/ready
// o_out       out  value, kind, last                    valid/ready
// cfg (APB)   in   paddr, pwdata -> prdata              psel/penable, pready high
//
// A sample or a reference query is handled without leaving the idle state; '@' gives two
// beats, minimum then maximum, back to back when the sink is ready. 'K' loads the window
// into the sort lanes, runs the WINDOW_SIZE phases of the odd-even sort, then loads the median.
// Reset is synchronous; it clears the window and control and sets min and max to their reset values at once.
// A result held in the output register blocks new input until its beat is taken.
// Top level of the tracker; depends on smmt_pkg, smmt_if, smmt_ctrl and smmt_dp.
module sensor_median_min_max_tracker
    import smmt_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    smmt_in_if.sink               i_in,
    smmt_out_if.source            o_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    t_smmt_cmd          cmd;
    t_smmt_sts          sts;
    logic [VALUE_W-1:0] r_ref_code;
    logic               reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1];
    assign prdata  = (reg_idx == REG_REF_CODE) ? APB_DATA_W'(r_ref_code) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_code <= REF_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_REF_CODE)) begin
            r_ref_code <= pwdata[VALUE_W-1:0];
        end
    end

    smmt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_sts      (sts),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd)
    );

    smmt_dp #(
        .WINDOW_SIZE (WINDOW_SIZE),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_opcode       (i_in.opcode),
        .i_sample       (i_in.sample),
        .i_command_char (i_in.command_char),
        .i_ref_code     (r_ref_code),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_value        (o_out.value),
        .o_kind         (o_out.kind),
        .o_last         (o_out.last)
    );

endmodule

// ===== sv/smmt_checker.sv =====
// Port-level assertions for the tracker, bound to the top level.
// Depends on smmt_pkg and sensor_median_min_max_tracker.
module smmt_checker
    import smmt_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic [VALUE_W-1:0] i_value,
    input logic [1:0]         i_kind,
    input logic               i_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_value) && $stable(i_kind)
            && $stable(i_last))
        else $error("Result beat changed while stalled.");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_last == (i_kind != KIND_MIN)))
        else $error("Last flag does not match result kind.");

    a_min_then_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && (i_kind == KIND_MIN) |=>
            i_out_valid && (i_kind == KIND_MAX))
        else $error("Minimum beat was not followed by the maximum beat.");

    a_no_accept_mid_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_kind == KIND_MIN) |-> !(i_in_valid && i_in_ready))
        else $error("Input accepted while a min/max pair was pending.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Result valid right after reset.");

endmodule

bind sensor_median_min_max_tracker smmt_checker u_smmt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_value     (o_out.value),
    .i_kind      (o_out.kind),
    .i_last      (o_out.last)
);
